>>> src/bfm_pkg.sv
// ----------------------------------------------------------------------------
// bfm_pkg
// shared types, constants and codes of the bloom filter hash unit
// ----------------------------------------------------------------------------
`default_nettype none

package bfm_pkg;

  localparam int DEF_MAX_CELLS  = 65536;
  localparam int DEF_MAX_HASHES = 16;
  localparam int QUEUE_DEPTH    = 2;

  localparam int HC_W   = 5;
  localparam int CC_W   = 17;
  localparam int SEED_W = 32;
  localparam int KEY_W  = 64;
  localparam int IDX_W  = 2;

  localparam logic [63:0] MIX_C1  = 64'h87c37b91114253d5;
  localparam logic [63:0] MIX_C2  = 64'h4cf5ad432745937f;
  localparam logic [63:0] FMIX_M1 = 64'hff51afd7ed558ccd;
  localparam logic [63:0] FMIX_M2 = 64'hc4ceb9fe1a85ec53;

  localparam logic [IDX_W-1:0] REG_HASH_COUNT = 2'd0;
  localparam logic [IDX_W-1:0] REG_CELL_COUNT = 2'd1;
  localparam logic [IDX_W-1:0] REG_HASH_SEED  = 2'd2;

  typedef enum logic [1:0] {
    OP_ADD    = 2'd0,
    OP_LOOKUP = 2'd1,
    OP_CLEAR  = 2'd2,
    OP_NOP    = 2'd3
  } op_t;

  typedef enum logic [1:0] {
    F_IDLE,
    F_HASH,
    F_PUSH
  } front_state_t;

  typedef enum logic [2:0] {
    B_INIT,
    B_IDLE,
    B_CLEAR,
    B_REM,
    B_PROBE,
    B_CHECK,
    B_DONE
  } back_state_t;

  typedef struct packed {
    op_t         op;
    logic [63:0] h1;
    logic [63:0] h2;
  } cmd_t;

  typedef struct packed {
    logic [HC_W-1:0] hash_count;
    logic [CC_W-1:0] cell_count;
  } cfg_t;

  function automatic logic [63:0] rotl31(input logic [63:0] x);
    rotl31 = {x[32:0], x[63:33]};
  endfunction

  function automatic logic [63:0] xshr33(input logic [63:0] x);
    xshr33 = x ^ {33'b0, x[63:33]};
  endfunction

endpackage

`default_nettype wire

>>> src/bfm_front.sv
// ----------------------------------------------------------------------------
// bfm_front
// accepts commands and computes the 128-bit key hash with a shared 32x32 multiplier
// ----------------------------------------------------------------------------
`default_nettype none

module bfm_front import bfm_pkg::*; (
  input  logic              clk,
  input  logic              rst,
  input  logic              start,
  input  op_t               op_in,
  input  logic [KEY_W-1:0]  key_in,
  input  logic [SEED_W-1:0] seed,
  output logic              busy,
  output cmd_t              cmd,
  output logic              cmd_valid,
  input  logic              cmd_ready
);

  front_state_t state, state_next;
  logic [2:0]   phase;
  logic [1:0]   sub;
  logic [63:0]  mop;
  logic [63:0]  acc;
  logic [63:0]  h1, h2;
  op_t          op;
  logic [63:0]  cval;
  logic [31:0]  a_sel, c_sel;
  logic [63:0]  pp, r;
  logic [63:0]  h1t, h2t, h1a, h2a, f2, h1n;
  logic         last_sub;

  always_comb begin
    case (phase)
      3'd0:    cval = MIX_C1;
      3'd1:    cval = MIX_C2;
      3'd2:    cval = FMIX_M1;
      3'd3:    cval = FMIX_M2;
      3'd4:    cval = FMIX_M1;
      default: cval = FMIX_M2;
    endcase
    a_sel = (sub == 2'd2) ? mop[63:32] : mop[31:0];
    c_sel = (sub == 2'd1) ? cval[63:32] : cval[31:0];
    pp    = a_sel * c_sel;
    r     = (sub == 2'd0) ? pp : acc + {pp[31:0], 32'b0};
    last_sub = (sub == 2'd2);
    h1t = {32'b0, seed} ^ r ^ 64'd8;
    h2t = {32'b0, seed} ^ 64'd8;
    h1a = h1t + h2t;
    h2a = h2t + h1a;
    f2  = xshr33(r);
    h1n = h1 + f2;
  end

  always_comb begin
    state_next = state;
    case (state)
      F_IDLE: begin
        if (start) begin
          if (op_in == OP_ADD || op_in == OP_LOOKUP) state_next = F_HASH;
          else state_next = F_PUSH;
        end
      end
      F_HASH: begin
        if (last_sub && phase == 3'd5) state_next = F_PUSH;
      end
      F_PUSH: begin
        if (cmd_ready) state_next = F_IDLE;
      end
      default: state_next = F_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) state <= F_IDLE;
    else state <= state_next;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase <= 3'd0;
      sub   <= 2'd0;
    end else if (state == F_IDLE) begin
      phase <= 3'd0;
      sub   <= 2'd0;
    end else if (state == F_HASH) begin
      if (last_sub) begin
        sub   <= 2'd0;
        phase <= phase + 3'd1;
      end else begin
        sub <= sub + 2'd1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (state == F_IDLE && start) begin
      op  <= op_in;
      mop <= key_in;
      h1  <= 64'b0;
      h2  <= 64'b0;
    end else if (state == F_HASH) begin
      acc <= r;
      if (last_sub) begin
        case (phase)
          3'd0: mop <= rotl31(r);
          3'd1: begin
            h1  <= h1a;
            h2  <= h2a;
            mop <= xshr33(h1a);
          end
          3'd2: mop <= xshr33(r);
          3'd3: begin
            h1  <= xshr33(r);
            mop <= xshr33(h2);
          end
          3'd4: mop <= xshr33(r);
          default: begin
            h1 <= h1n;
            h2 <= f2 + h1n;
          end
        endcase
      end
    end
  end

  assign busy      = (state != F_IDLE);
  assign cmd_valid = (state == F_PUSH);
  assign cmd.op    = op;
  assign cmd.h1    = h1;
  assign cmd.h2    = h2;

endmodule

`default_nettype wire

>>> src/bfm_cmd_queue.sv
// ----------------------------------------------------------------------------
// bfm_cmd_queue
// short command queue between the hash front and the probe back
// ----------------------------------------------------------------------------
`default_nettype none

module bfm_cmd_queue import bfm_pkg::*; (
  input  logic clk,
  input  logic rst,
  input  cmd_t wr_cmd,
  input  logic wr_valid,
  output logic wr_ready,
  output cmd_t rd_cmd,
  output logic rd_valid,
  input  logic rd_ready
);

  localparam int PTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

  cmd_t             slots [QUEUE_DEPTH];
  logic [PTR_W-1:0] wr_ptr, rd_ptr;
  logic [CNT_W-1:0] count;
  logic             do_wr, do_rd;

  assign wr_ready = (count != CNT_W'(QUEUE_DEPTH));
  assign rd_valid = (count != '0);
  assign do_wr    = wr_valid && wr_ready;
  assign do_rd    = rd_valid && rd_ready;
  assign rd_cmd   = slots[rd_ptr];

  always_ff @(posedge clk) begin
    if (do_wr) slots[wr_ptr] <= wr_cmd;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (do_wr) wr_ptr <= (wr_ptr == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr + 1'b1;
      if (do_rd) rd_ptr <= (rd_ptr == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr + 1'b1;
      if (do_wr && !do_rd) count <= count + 1'b1;
      else if (do_rd && !do_wr) count <= count - 1'b1;
    end
  end

endmodule

`default_nettype wire

>>> src/bfm_back.sv
// ----------------------------------------------------------------------------
// bfm_back
// probe engine: remainder lanes, double-hash probe walk and the bit array
// ----------------------------------------------------------------------------
`default_nettype none

module bfm_back import bfm_pkg::*; #(
  parameter int MAX_CELLS  = DEF_MAX_CELLS,
  parameter int MAX_HASHES = DEF_MAX_HASHES
) (
  input  logic clk,
  input  logic rst,
  input  cfg_t cfg,
  input  cmd_t cmd,
  input  logic cmd_valid,
  output logic cmd_ready,
  output logic init_busy,
  output logic res_valid,
  output logic res_present,
  input  logic res_pop
);

  localparam int AW    = $clog2(MAX_CELLS);
  localparam int CW    = AW + 1;
  localparam int PW    = $clog2(MAX_HASHES + 1);
  localparam int DIG   = 4;
  localparam int STEPS = 64 / DIG;
  localparam int SW    = $clog2(STEPS);

  back_state_t state, state_next;
  logic          mem [MAX_CELLS];
  logic          rd_bit;
  logic          we, wd;
  logic [AW-1:0] addr;
  logic [AW-1:0] sweep;
  logic [SW-1:0] step;
  logic [63:0]   div [3];
  logic [CW-1:0] rem [3];
  logic [CW-1:0] rem_next [3];
  logic [CW-1:0] cells;
  logic [PW-1:0] probes;
  logic [PW-1:0] cnt;
  logic [CW-1:0] r, h2m, kk;
  logic [CW-1:0] r1, r2, kx;
  logic [CW:0]   sum1;
  logic [63:0]   s, h2, s_next;
  logic          carry;
  op_t           op;
  logic          pres;
  logic          slot_free;

  function automatic logic [CW-1:0] rem_step(input logic [CW-1:0] ri,
                                             input logic [DIG-1:0] bits,
                                             input logic [CW-1:0] c);
    logic [CW:0]   t;
    logic [CW-1:0] rr;
    rr = ri;
    for (int d = DIG - 1; d >= 0; d--) begin
      t = {rr, bits[d]};
      if (t >= {1'b0, c}) t = t - {1'b0, c};
      rr = t[CW-1:0];
    end
    rem_step = rr;
  endfunction

  always_comb begin
    if (cfg.cell_count == '0) cells = CW'(1);
    else if (32'(cfg.cell_count) > 32'(MAX_CELLS)) cells = CW'(MAX_CELLS);
    else cells = CW'(cfg.cell_count);
    if (32'(cfg.hash_count) > 32'(MAX_HASHES)) probes = PW'(MAX_HASHES);
    else probes = PW'(cfg.hash_count);
  end

  always_comb begin
    for (int l = 0; l < 3; l++) rem_next[l] = rem_step(rem[l], div[l][63:64-DIG], cells);
    kx = (rem_next[2] + 1'b1 == cells) ? '0 : rem_next[2] + 1'b1;
    sum1 = {1'b0, r} + {1'b0, h2m};
    r1 = (sum1 >= {1'b0, cells}) ? CW'(sum1 - {1'b0, cells}) : sum1[CW-1:0];
    {carry, s_next} = {1'b0, s} + {1'b0, h2};
    if (!carry) r2 = r1;
    else if (r1 >= kk) r2 = r1 - kk;
    else r2 = r1 + cells - kk;
  end

  assign slot_free = !res_valid || res_pop;

  always_comb begin
    state_next = state;
    cmd_ready  = 1'b0;
    case (state)
      B_INIT, B_CLEAR: begin
        if (sweep == AW'(MAX_CELLS - 1)) state_next = (state == B_INIT) ? B_IDLE : B_DONE;
      end
      B_IDLE: begin
        if (cmd_valid) begin
          cmd_ready = 1'b1;
          case (cmd.op)
            OP_CLEAR:            state_next = B_CLEAR;
            OP_ADD, OP_LOOKUP:   state_next = B_REM;
            default:             state_next = B_DONE;
          endcase
        end
      end
      B_REM: begin
        if (step == SW'(STEPS - 1)) state_next = B_PROBE;
      end
      B_PROBE: begin
        if (cnt == probes) state_next = B_DONE;
        else if (op == OP_LOOKUP) state_next = B_CHECK;
      end
      B_CHECK: begin
        state_next = rd_bit ? B_PROBE : B_DONE;
      end
      B_DONE: begin
        if (slot_free) state_next = B_IDLE;
      end
      default: state_next = B_IDLE;
    endcase
  end

  always_comb begin
    we   = 1'b0;
    wd   = 1'b0;
    addr = r[AW-1:0];
    if (state == B_INIT || state == B_CLEAR) begin
      we   = 1'b1;
      addr = sweep;
    end else if (state == B_PROBE && op == OP_ADD && cnt != probes) begin
      we = 1'b1;
      wd = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (we) mem[addr] <= wd;
    rd_bit <= mem[addr];
  end

  always_ff @(posedge clk) begin
    if (rst) state <= B_INIT;
    else state <= state_next;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      sweep     <= '0;
      res_valid <= 1'b0;
    end else begin
      if (state == B_INIT || state == B_CLEAR) sweep <= sweep + 1'b1;
      else sweep <= '0;
      if (state == B_DONE && slot_free) res_valid <= 1'b1;
      else if (res_pop) res_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (state == B_DONE && slot_free) res_present <= pres;
    case (state)
      B_IDLE: begin
        op     <= cmd.op;
        pres   <= (cmd.op == OP_LOOKUP);
        h2     <= cmd.h2;
        s      <= cmd.h1;
        div[0] <= cmd.h1;
        div[1] <= cmd.h2;
        div[2] <= '1;
        for (int l = 0; l < 3; l++) rem[l] <= '0;
        step   <= '0;
        cnt    <= '0;
      end
      B_REM: begin
        for (int l = 0; l < 3; l++) begin
          rem[l] <= rem_next[l];
          div[l] <= {div[l][63-DIG:0], {DIG{1'b0}}};
        end
        step <= step + 1'b1;
        if (step == SW'(STEPS - 1)) begin
          r   <= rem_next[0];
          h2m <= rem_next[1];
          kk  <= kx;
        end
      end
      B_PROBE: begin
        if (cnt != probes) begin
          r   <= r2;
          s   <= s_next;
          cnt <= cnt + 1'b1;
        end
      end
      B_CHECK: begin
        if (!rd_bit) pres <= 1'b0;
      end
      default: begin
      end
    endcase
  end

  assign init_busy = (state == B_INIT);

endmodule

`default_nettype wire

>>> src/bloom_filter_murmur_double_hash_unit.sv
// ----------------------------------------------------------------------------
// bloom_filter_murmur_double_hash_unit
// bloom filter with murmur3 x64_128 double hashing over a single-port bit array
// ----------------------------------------------------------------------------
// channel   direction  handshake           payload
// command   in         push / full         opcode, key_value
// result    out        empty / pop         present
// config    in         cfg_write           cfg_index, cfg_data
//
// add and lookup are hashed on one shared 32x32 multiplier, then reduced to
// remainders against the cell count, then probed; lookup reads each probe
// from the bit array through a registered read before the next probe.
// clear sweeps the whole array; reset runs the same sweep, with full high,
// before the first command is taken.
// a command queue lets hashing continue while the probe engine or the
// result register is stalled.
// ----------------------------------------------------------------------------
`default_nettype none

module bloom_filter_murmur_double_hash_unit import bfm_pkg::*; #(
  parameter int MAX_CELLS  = DEF_MAX_CELLS,
  parameter int MAX_HASHES = DEF_MAX_HASHES
) (
  input  logic                    clk,
  input  logic                    rst,
  input  logic                    push,
  output logic                    full,
  input  logic [1:0]              opcode,
  input  logic signed [KEY_W-1:0] key_value,
  output logic                    empty,
  input  logic                    pop,
  output logic                    present,
  input  logic                    cfg_write,
  input  logic [IDX_W-1:0]        cfg_index,
  input  logic [SEED_W-1:0]       cfg_data
);

  cfg_t              cfg;
  logic [SEED_W-1:0] hash_seed;
  logic              front_busy, init_busy;
  logic              start;
  cmd_t              f_cmd, q_cmd;
  logic              f_valid, f_ready, q_valid, q_ready;
  logic              res_valid;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.hash_count <= HC_W'(7);
      cfg.cell_count <= CC_W'(65536);
      hash_seed      <= '0;
    end else if (cfg_write) begin
      case (cfg_index)
        REG_HASH_COUNT: cfg.hash_count <= cfg_data[HC_W-1:0];
        REG_CELL_COUNT: cfg.cell_count <= cfg_data[CC_W-1:0];
        REG_HASH_SEED:  hash_seed      <= cfg_data;
        default: begin
        end
      endcase
    end
  end

  assign full  = front_busy || init_busy;
  assign start = push && !full;
  assign empty = !res_valid;

  bfm_front u_front (
    .clk       (clk),
    .rst       (rst),
    .start     (start),
    .op_in     (op_t'(opcode)),
    .key_in    (key_value),
    .seed      (hash_seed),
    .busy      (front_busy),
    .cmd       (f_cmd),
    .cmd_valid (f_valid),
    .cmd_ready (f_ready)
  );

  bfm_cmd_queue u_queue (
    .clk      (clk),
    .rst      (rst),
    .wr_cmd   (f_cmd),
    .wr_valid (f_valid),
    .wr_ready (f_ready),
    .rd_cmd   (q_cmd),
    .rd_valid (q_valid),
    .rd_ready (q_ready)
  );

  bfm_back #(
    .MAX_CELLS  (MAX_CELLS),
    .MAX_HASHES (MAX_HASHES)
  ) u_back (
    .clk         (clk),
    .rst         (rst),
    .cfg         (cfg),
    .cmd         (q_cmd),
    .cmd_valid   (q_valid),
    .cmd_ready   (q_ready),
    .init_busy   (init_busy),
    .res_valid   (res_valid),
    .res_present (present),
    .res_pop     (pop)
  );

endmodule

`default_nettype wire

>>> src/bfm_checker.sv
// ----------------------------------------------------------------------------
// bfm_checker
// port-level assertions for the bloom filter hash unit
// ----------------------------------------------------------------------------
`default_nettype none

module bfm_checker (
  input logic clk,
  input logic rst,
  input logic push,
  input logic full,
  input logic empty,
  input logic pop,
  input logic present
);

  // reset starts the array sweep, so no command is taken right after
  a_full_after_rst: assert property (@(posedge clk) rst |=> full)
    else $error("full low right after reset");

  a_empty_after_rst: assert property (@(posedge clk) rst |=> empty)
    else $error("result shown right after reset");

  // hashing is one command at a time
  a_busy_after_push: assert property (@(posedge clk) disable iff (rst)
    push && !full |=> full)
    else $error("front took a transaction without going busy");

  a_result_holds: assert property (@(posedge clk) disable iff (rst)
    !empty && !pop |=> !empty)
    else $error("waiting result dropped");

  a_present_holds: assert property (@(posedge clk) disable iff (rst)
    !empty && !pop |=> $stable(present))
    else $error("waiting result changed");

endmodule

bind bloom_filter_murmur_double_hash_unit bfm_checker u_bfm_checker (
  .clk     (clk),
  .rst     (rst),
  .push    (push),
  .full    (full),
  .empty   (empty),
  .pop     (pop),
  .present (present)
);

`default_nettype wire
